>>> hdl/nirdec_pkg.sv
// Shared types, constants and a helper function of the NEC IR frame decoder.
package nirdec_pkg;

    localparam int TIME_W      = 32;
    localparam int WIN_W       = 16;
    localparam int BYTE_W      = 8;
    localparam int FRAME_BITS  = 32;
    localparam int CNT_W       = $clog2(FRAME_BITS + 1);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [WIN_W-1:0] LEADER_LOW_RST  = 16'd13000;
    localparam logic [WIN_W-1:0] LEADER_HIGH_RST = 16'd14000;
    localparam logic [WIN_W-1:0] ZERO_LOW_RST    = 16'd1100;
    localparam logic [WIN_W-1:0] ZERO_HIGH_RST   = 16'd1200;
    localparam logic [WIN_W-1:0] ONE_LOW_RST     = 16'd2200;
    localparam logic [WIN_W-1:0] ONE_HIGH_RST    = 16'd2300;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEADER_LOW  = 3'd0,
        CFG_LEADER_HIGH = 3'd1,
        CFG_ZERO_LOW    = 3'd2,
        CFG_ZERO_HIGH   = 3'd3,
        CFG_ONE_LOW     = 3'd4,
        CFG_ONE_HIGH    = 3'd5,
        CFG_IND_ENABLE  = 3'd6
    } t_cfg_index;

    typedef struct packed {
        logic [WIN_W-1:0] leader_low;
        logic [WIN_W-1:0] leader_high;
        logic [WIN_W-1:0] zero_low;
        logic [WIN_W-1:0] zero_high;
        logic [WIN_W-1:0] one_low;
        logic [WIN_W-1:0] one_high;
    } t_windows;

    typedef enum logic [1:0] {
        BIT_NONE = 2'd0,
        BIT_ZERO = 2'd1,
        BIT_ONE  = 2'd2
    } t_bit_class;

    // Classified interval handed from the front end to the frame engine.
    typedef struct packed {
        logic       leader;
        t_bit_class bit_class;
    } t_edge_class;

    localparam int CLASS_W = $bits(t_edge_class);

    typedef enum logic {
        RX_IDLE = 1'b0,
        RX_DATA = 1'b1
    } t_rx_state;

    function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++) begin
            r[i] = b[BYTE_W-1-i];
        end
        return r;
    endfunction

endpackage

>>> hdl/nec_ir_frame_decoder_unit.sv
// NEC IR frame decoder top level: configuration registers and front/back assembly.
//
// Feed the timestamp of every falling edge of the demodulated IR signal as one
// input beat; each beat yields exactly one result beat. The interval since the
// previous edge (32-bit wrapping difference) starts a frame when it lies
// strictly inside the leader window, and while a frame is open it shifts in a
// zero or one bit when inside the zero or one window (zero wins on overlap);
// anything else drops the frame. After 32 bits the result carries frame_done,
// the raw code (first bit in the MSB), the bit-reversed address, command and
// their check bytes, and frame_ok when each byte shares no set bit with its
// check byte; on other edges those fields are zero. Every edge time is
// recorded, so the next interval is always measured from the latest edge.
// Repeat codes are not decoded. The block takes one edge per clock cycle while
// the queue has room: the front end subtracts and compares in the cycle it
// accepts a beat and pushes the classification into a two-entry queue; unless
// the output stalls, the frame engine pops one entry a cycle into the result
// register, and the input only stalls once the queue fills behind a stalled
// output. Write the window registers and indicator enable only while no beat
// is in flight; the configuration port is always ready and ignores index 7.
module nec_ir_frame_decoder_unit #(
    parameter int QUEUE_DEPTH = nirdec_pkg::QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Edge channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [nirdec_pkg::TIME_W-1:0]       i_edge_time,
    // Result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_receiving_indicator,
    output logic                                o_frame_done,
    output logic                                o_frame_ok,
    output logic [nirdec_pkg::FRAME_BITS-1:0]   o_raw_code,
    output logic [nirdec_pkg::BYTE_W-1:0]       o_address,
    output logic [nirdec_pkg::BYTE_W-1:0]       o_address_check,
    output logic [nirdec_pkg::BYTE_W-1:0]       o_command,
    output logic [nirdec_pkg::BYTE_W-1:0]       o_command_check,
    // Configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [nirdec_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nirdec_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import nirdec_pkg::*;

    t_windows    r_windows;
    logic        r_ind_enable;
    logic        w_in_accept;
    logic        w_queue_full;
    logic        w_queue_empty;
    logic        w_queue_pop;
    t_edge_class w_front_class;
    t_edge_class w_back_class;

    assign o_cfg_ready = 1'b1;
    assign w_in_accept = i_in_valid && !w_queue_full;
    assign o_in_stall  = w_queue_full;

    // Configuration registers; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_windows.leader_low  <= LEADER_LOW_RST;
            r_windows.leader_high <= LEADER_HIGH_RST;
            r_windows.zero_low    <= ZERO_LOW_RST;
            r_windows.zero_high   <= ZERO_HIGH_RST;
            r_windows.one_low     <= ONE_LOW_RST;
            r_windows.one_high    <= ONE_HIGH_RST;
            r_ind_enable          <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_LEADER_LOW:  r_windows.leader_low  <= i_cfg_data;
                CFG_LEADER_HIGH: r_windows.leader_high <= i_cfg_data;
                CFG_ZERO_LOW:    r_windows.zero_low    <= i_cfg_data;
                CFG_ZERO_HIGH:   r_windows.zero_high   <= i_cfg_data;
                CFG_ONE_LOW:     r_windows.one_low     <= i_cfg_data;
                CFG_ONE_HIGH:    r_windows.one_high    <= i_cfg_data;
                CFG_IND_ENABLE:  r_ind_enable          <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    nirdec_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_in_accept),
        .i_edge_time (i_edge_time),
        .i_windows   (r_windows),
        .o_class     (w_front_class)
    );

    nirdec_queue #(
        .WIDTH (CLASS_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_in_accept),
        .i_data  (w_front_class),
        .o_full  (w_queue_full),
        .i_pop   (w_queue_pop),
        .o_data  (w_back_class),
        .o_empty (w_queue_empty)
    );

    nirdec_back u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_class_valid         (!w_queue_empty),
        .i_class               (w_back_class),
        .o_class_pop           (w_queue_pop),
        .i_indicator_enable    (r_ind_enable),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_receiving_indicator (o_receiving_indicator),
        .o_frame_done          (o_frame_done),
        .o_frame_ok            (o_frame_ok),
        .o_raw_code            (o_raw_code),
        .o_address             (o_address),
        .o_address_check       (o_address_check),
        .o_command             (o_command),
        .o_command_check       (o_command_check)
    );

endmodule

>>> hdl/nirdec_queue.sv
// Small register-based FIFO between the interval classifier and the frame engine.
module nirdec_queue #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> hdl/nirdec_front.sv
// Front end: measures the edge interval and classifies it against the windows.
module nirdec_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic [nirdec_pkg::TIME_W-1:0]       i_edge_time,
    input  nirdec_pkg::t_windows                i_windows,
    output nirdec_pkg::t_edge_class             o_class
);
    import nirdec_pkg::*;

    logic [TIME_W-1:0] r_last_time;
    logic [TIME_W-1:0] w_diff;
    logic              w_in_zero;
    logic              w_in_one;

    // Wrapping subtraction handles timer rollover.
    assign w_diff = i_edge_time - r_last_time;

    assign w_in_zero = (w_diff > TIME_W'(i_windows.zero_low))
                    && (w_diff < TIME_W'(i_windows.zero_high));
    assign w_in_one  = (w_diff > TIME_W'(i_windows.one_low))
                    && (w_diff < TIME_W'(i_windows.one_high));

    always_comb begin
        o_class.leader = (w_diff > TIME_W'(i_windows.leader_low))
                      && (w_diff < TIME_W'(i_windows.leader_high));
        // Zero wins where the bit windows overlap.
        if (w_in_zero) begin
            o_class.bit_class = BIT_ZERO;
        end else if (w_in_one) begin
            o_class.bit_class = BIT_ONE;
        end else begin
            o_class.bit_class = BIT_NONE;
        end
    end

    // Record every edge, also ones that abort or complete a frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
        end else if (i_accept) begin
            r_last_time <= i_edge_time;
        end
    end

endmodule

>>> hdl/nirdec_back.sv
// Frame engine: tracks reception, shifts bits in and registers one result per edge.
module nirdec_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_class_valid,
    input  nirdec_pkg::t_edge_class             i_class,
    output logic                                o_class_pop,
    input  logic                                i_indicator_enable,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_receiving_indicator,
    output logic                                o_frame_done,
    output logic                                o_frame_ok,
    output logic [nirdec_pkg::FRAME_BITS-1:0]   o_raw_code,
    output logic [nirdec_pkg::BYTE_W-1:0]       o_address,
    output logic [nirdec_pkg::BYTE_W-1:0]       o_address_check,
    output logic [nirdec_pkg::BYTE_W-1:0]       o_command,
    output logic [nirdec_pkg::BYTE_W-1:0]       o_command_check
);
    import nirdec_pkg::*;

    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(FRAME_BITS - 1);

    t_rx_state             r_state, n_state;
    logic [CNT_W-1:0]      r_bit_count, n_bit_count;
    logic [FRAME_BITS-1:0] r_shift_code, n_shift_code;
    logic                  r_out_valid, n_out_valid;
    logic                  w_pop;
    logic                  w_is_bit;
    logic                  w_done;
    logic [FRAME_BITS-1:0] w_code;
    logic [BYTE_W-1:0]     w_adr, w_adr_c, w_cmd, w_cmd_c;

    assign w_pop       = i_class_valid && (!r_out_valid || !i_out_stall);
    assign o_class_pop = w_pop;
    assign o_out_valid = r_out_valid;
    assign w_is_bit    = (i_class.bit_class != BIT_NONE);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            RX_IDLE: begin
                if (i_class.leader) begin
                    n_state = RX_DATA;
                end
            end
            RX_DATA: begin
                if (!w_is_bit || r_bit_count == LAST_BIT) begin
                    n_state = RX_IDLE;
                end
            end
            default: n_state = RX_IDLE;
        endcase
    end

    // Datapath and result decode.
    always_comb begin
        n_bit_count  = r_bit_count;
        n_shift_code = r_shift_code;
        w_done       = 1'b0;
        case (r_state)
            RX_IDLE: begin
                if (i_class.leader) begin
                    n_bit_count  = '0;
                    n_shift_code = '0;
                end
            end
            RX_DATA: begin
                if (w_is_bit) begin
                    n_bit_count  = r_bit_count + CNT_W'(1);
                    n_shift_code = {r_shift_code[FRAME_BITS-2:0],
                                    (i_class.bit_class == BIT_ONE)};
                    w_done       = (r_bit_count == LAST_BIT);
                end
            end
            default: begin
                n_bit_count = '0;
            end
        endcase
        w_code  = w_done ? n_shift_code : '0;
        w_adr   = rev8(w_code[31:24]);
        w_adr_c = rev8(w_code[23:16]);
        w_cmd   = rev8(w_code[15:8]);
        w_cmd_c = rev8(w_code[7:0]);
    end

    always_comb begin
        if (w_pop) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= RX_IDLE;
            r_bit_count  <= '0;
            r_shift_code <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_pop) begin
                r_state      <= n_state;
                r_bit_count  <= n_bit_count;
                r_shift_code <= n_shift_code;
            end
        end
    end

    // Result register; holds while the downstream side stalls.
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            o_receiving_indicator <= (n_state == RX_DATA) && i_indicator_enable;
            o_frame_done          <= w_done;
            o_frame_ok            <= w_done && ((w_adr & w_adr_c) == '0)
                                            && ((w_cmd & w_cmd_c) == '0);
            o_raw_code            <= w_code;
            o_address             <= w_adr;
            o_address_check       <= w_adr_c;
            o_command             <= w_cmd;
            o_command_check       <= w_cmd_c;
        end
    end

endmodule
